FILE: rtl/dual_parity_block_generator_top_macros.svh
// Assertion macros for the dual parity block generator.
`ifndef DUAL_PARITY_BLOCK_GENERATOR_TOP_MACROS_SVH
`define DUAL_PARITY_BLOCK_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DPBG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dpbg assertion failed");
`define DPBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dpbg assertion failed");
`else
`define DPBG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DPBG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/dpbg_pkg.sv
// Shared constants, types and GF(2^8) arithmetic for the dual parity block generator.
`default_nettype none
package dpbg_pkg;

  localparam int LaneCount = 8;
  localparam int ByteBits = 8;
  localparam int SymBits = LaneCount * ByteBits;
  localparam int IndexBits = 32;
  localparam int StartBits = 32;
  localparam int CountBits = 8;
  localparam int AddrBits = 3;

  localparam logic [ByteBits-1:0] GfReduce = 8'h1d;
  localparam logic [ByteBits-1:0] GfTop = 8'h80;
  localparam logic [CountBits-1:0] BlockLenReset = 8'd64;

  localparam logic [AddrBits-3:0] RegBlockLength = 1'b0;

  typedef struct packed {
    logic [StartBits-1:0] start;
    logic [CountBits-1:0] count;
    logic                 last;
  } blk_meta_t;

  function automatic logic [ByteBits-1:0] gf_mul(input logic [ByteBits-1:0] a,
                                                 input logic [ByteBits-1:0] b);
    logic [ByteBits-1:0] acc;
    logic [ByteBits-1:0] x;
    acc = '0;
    x = a;
    for (int i = 0; i < ByteBits; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      if ((x & GfTop) != '0) begin
        x = {x[ByteBits-2:0], 1'b0} ^ GfReduce;
      end else begin
        x = {x[ByteBits-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dpbg_if.sv
// Streaming channel interfaces for symbols in and parity blocks out.
`default_nettype none
interface dpbg_sym_if;
  logic        valid;
  logic        ready;
  logic [63:0] symbol;
  logic        end_of_trail;

  modport source (output valid, output symbol, output end_of_trail, input ready);
  modport sink (input valid, input symbol, input end_of_trail, output ready);
endinterface

interface dpbg_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] p_parity;
  logic [63:0] q_parity;
  logic [31:0] block_start;
  logic [7:0]  symbol_count;
  logic        final_block;

  modport source (output valid, output p_parity, output q_parity, output block_start,
                  output symbol_count, output final_block, input ready);
  modport sink (input valid, input p_parity, input q_parity, input block_start,
                input symbol_count, input final_block, output ready);
endinterface
`default_nettype wire

FILE: rtl/dpbg_lane.sv
// One byte lane: P and Q accumulators with a GF(2^8) scaler.
`default_nettype none
module dpbg_lane (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic                          close_i,
  input  wire logic [dpbg_pkg::ByteBits-1:0] byte_i,
  input  wire logic [dpbg_pkg::ByteBits-1:0] coeff_i,
  output logic      [dpbg_pkg::ByteBits-1:0] p_o,
  output logic      [dpbg_pkg::ByteBits-1:0] q_o
);
  import dpbg_pkg::*;

  logic [ByteBits-1:0] p_q, p_d;
  logic [ByteBits-1:0] q_q, q_d;

  assign p_o = p_q ^ byte_i;
  assign q_o = q_q ^ gf_mul(coeff_i, byte_i);

  always_comb begin
    p_d = p_q;
    q_d = q_q;
    if (fire_i) begin
      if (close_i) begin
        p_d = '0;
        q_d = '0;
      end else begin
        p_d = p_o;
        q_d = q_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      q_q <= '0;
    end else begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/dpbg_merge.sv
// Merge stage: gather lane parities into a block result and hold it in the output register.
`default_nettype none
module dpbg_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic [dpbg_pkg::ByteBits-1:0] p_i [dpbg_pkg::LaneCount],
  input  wire logic [dpbg_pkg::ByteBits-1:0] q_i [dpbg_pkg::LaneCount],
  input  wire dpbg_pkg::blk_meta_t           meta_i,
  output logic                               space_o,
  dpbg_blk_if.source                         out_o
);
  import dpbg_pkg::*;

  logic                 valid_q, valid_d;
  logic [SymBits-1:0]   p_q, p_d;
  logic [SymBits-1:0]   q_q, q_d;
  blk_meta_t            meta_q;

  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    for (int k = 0; k < LaneCount; k++) begin
      p_d[k*ByteBits +: ByteBits] = p_i[k];
      q_d[k*ByteBits +: ByteBits] = q_i[k];
    end
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q    <= p_d;
      q_q    <= q_d;
      meta_q <= meta_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.p_parity     = p_q;
  assign out_o.q_parity     = q_q;
  assign out_o.block_start  = meta_q.start;
  assign out_o.symbol_count = meta_q.count;
  assign out_o.final_block  = meta_q.last;
endmodule
`default_nettype wire

FILE: rtl/dual_parity_block_generator_top.sv
// Top level of the dual parity block generator: APB register, block control, lanes, merge.
// Takes one 64-bit symbol per cycle; eight byte lanes accumulate P and Q side by side.
// A result is valid in the cycle after the symbol that closes its block is taken.
// Throughput is one symbol per cycle; input stalls only while the output register is full
// and not being taken.
// Reset clears the accumulators, counters and output valid, and sets block_length to 64.
`default_nettype none
module dual_parity_block_generator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dpbg_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  dpbg_sym_if.sink                           in_i,
  dpbg_blk_if.source                         out_o
);
  import dpbg_pkg::*;

  `include "dual_parity_block_generator_top_macros.svh"

  logic [CountBits-1:0] blk_len_q;
  logic [CountBits-1:0] pos_q, pos_d;
  logic [IndexBits-1:0] trail_q, trail_d;
  logic [IndexBits-1:0] start_q, start_d;
  logic [CountBits-1:0] count;
  logic                 space;
  logic                 accept;
  logic                 fire;
  logic                 close;
  logic                 reg_sel;
  blk_meta_t            meta;
  logic [ByteBits-1:0]  lane_p [LaneCount];
  logic [ByteBits-1:0]  lane_q [LaneCount];

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrBits-1:2] == RegBlockLength;
  assign prdata  = reg_sel ? 32'(blk_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len_q <= BlockLenReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      blk_len_q <= pwdata[CountBits-1:0];
    end
  end

  assign in_i.ready = space;
  assign accept     = in_i.valid && in_i.ready;
  assign fire       = accept && (blk_len_q != '0);
  assign count      = pos_q + CountBits'(1);
  assign close      = (count >= blk_len_q) || in_i.end_of_trail;

  always_comb begin
    pos_d   = pos_q;
    trail_d = trail_q;
    start_d = start_q;
    if (fire) begin
      trail_d = in_i.end_of_trail ? '0 : trail_q + IndexBits'(1);
      if (close) begin
        pos_d   = '0;
        start_d = trail_d;
      end else begin
        pos_d = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      trail_q <= '0;
      start_q <= '0;
    end else begin
      pos_q   <= pos_d;
      trail_q <= trail_d;
      start_q <= start_d;
    end
  end

  for (genvar k = 0; k < LaneCount; k++) begin : g_lane
    dpbg_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .fire_i  (fire),
      .close_i (close),
      .byte_i  (in_i.symbol[k*ByteBits +: ByteBits]),
      .coeff_i (count),
      .p_o     (lane_p[k]),
      .q_o     (lane_q[k])
    );
  end

  assign meta.start = StartBits'(start_q);
  assign meta.count = count;
  assign meta.last  = in_i.end_of_trail;

  dpbg_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && close),
    .p_i     (lane_p),
    .q_i     (lane_q),
    .meta_i  (meta),
    .space_o (space),
    .out_o   (out_o)
  );

  `DPBG_ASSERT_SAME(a_pos_bound, clk_i, rst_ni, 1'b1, pos_q != '1)
  `DPBG_ASSERT_NEXT(a_close_clears, clk_i, rst_ni, fire && close, pos_q == '0 && out_o.valid)
  `DPBG_ASSERT_SAME(a_stall_blocks, clk_i, rst_ni, out_o.valid && !out_o.ready, !in_i.ready)
  `DPBG_ASSERT_NEXT(a_trail_restart, clk_i, rst_ni, fire && in_i.end_of_trail,
                    trail_q == '0 && start_q == '0)
endmodule
`default_nettype wire
